/* rtl/cau_pkg.sv */
// Package for the complex arithmetic unit: widths, operation and status codes,
// request/result structs and the saturation helper.
// No dependencies.
package cau_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;

    localparam int PROD_W  = 2 * DATA_WIDTH;          // one full product
    localparam int SUM_W   = PROD_W + 1;              // sum of two products
    localparam int DEN_W   = PROD_W;                  // b_re^2 + b_im^2
    localparam int NUM_W   = SUM_W + FRAC_BITS;       // scaled dividend / remainder
    localparam int CMP_W   = NUM_W + DATA_WIDTH + 1;  // room for den shifted by quotient width
    localparam int DIV_ST  = (DATA_WIDTH + 1) / 2;    // two quotient bits per stage
    localparam int LATENCY = DIV_ST + 5;              // accept edge to result edge

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_SAT  = 2'd1,
        STAT_DIVZ = 2'd2
    } status_t;

    typedef struct packed {
        func_t                         func;
        logic signed [DATA_WIDTH-1:0]  a_re;
        logic signed [DATA_WIDTH-1:0]  a_im;
        logic signed [DATA_WIDTH-1:0]  b_re;
        logic signed [DATA_WIDTH-1:0]  b_im;
    } req_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  out_re;
        logic signed [DATA_WIDTH-1:0]  out_im;
        status_t                       status;
    } result_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  v;
        logic                          sat;
    } satv_t;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(64'sd1 <<< (DATA_WIDTH - 1));

    // clamp a wide signed value into the output range
    function automatic satv_t sat_val(input logic signed [SUM_W-1:0] x);
        satv_t r;
        if (x > SAT_HI)
        begin
            r.v   = DATA_WIDTH'(SAT_HI);
            r.sat = 1'b1;
        end
        else if (x < SAT_LO)
        begin
            r.v   = DATA_WIDTH'(SAT_LO);
            r.sat = 1'b1;
        end
        else
        begin
            r.v   = DATA_WIDTH'(x);
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

/* rtl/complex_arithmetic_unit.sv */
// Complex arithmetic unit: fully pipelined complex add/sub/mul/div in Q8.8.
// Depends on cau_pkg.
//
// One request can be issued every clock cycle; busy is never raised. Each
// request returns exactly one result, marked by done for one cycle, after
// passing through an input register, a product stage, a sum stage, a divide
// setup stage, one restoring divider stage per two quotient bits, and the
// output register. All operations pass through the same stages so results
// come back in request order. The receiver must take each result in the cycle
// it is shown.
module complex_arithmetic_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cau_pkg::req_t    req,
    output logic             done,
    output cau_pkg::result_t result
);

    localparam int DW = cau_pkg::DATA_WIDTH;
    localparam int FB = cau_pkg::FRAC_BITS;
    localparam int PW = cau_pkg::PROD_W;
    localparam int SW = cau_pkg::SUM_W;
    localparam int NW = cau_pkg::NUM_W;
    localparam int CW = cau_pkg::CMP_W;
    localparam int DS = cau_pkg::DIV_ST;
    localparam logic [DW-1:0] Q_POS_MAX = DW'((64'd1 << (DW - 1)) - 1);
    localparam logic [DW-1:0] Q_NEG_MAX = DW'(64'd1 << (DW - 1));

    typedef struct packed {
        cau_pkg::func_t    func;
        logic signed [PW-1:0] p_rr;
        logic signed [PW-1:0] p_ii;
        logic signed [PW-1:0] p_ri;
        logic signed [PW-1:0] p_ir;
        logic [PW-1:0]        br2;
        logic [PW-1:0]        bi2;
        logic signed [DW-1:0] a_re;
        logic signed [DW-1:0] a_im;
        logic signed [DW-1:0] b_re;
        logic signed [DW-1:0] b_im;
    } prod_t;

    typedef struct packed {
        cau_pkg::func_t    func;
        logic signed [SW-1:0] sum_re;
        logic signed [SW-1:0] sum_im;
        logic [PW-1:0]        den;
    } sum_t;

    typedef struct packed {
        logic                 is_div;
        logic                 divz;
        logic                 re_neg;
        logic                 im_neg;
        logic                 re_ov;
        logic                 im_ov;
        logic [NW-1:0]        rem_re;
        logic [NW-1:0]        rem_im;
        logic [DW-1:0]        q_re;
        logic [DW-1:0]        q_im;
        logic [PW-1:0]        den;
        cau_pkg::result_t     res;
    } div_t;

    logic              v1_reg, v2_reg, v3_reg, vo_reg;
    logic [DS:0]       vd_reg;
    cau_pkg::req_t     s1_reg;
    prod_t             s2_reg, s2_next;
    sum_t              s3_reg, s3_next;
    div_t              dp0_next;
    div_t              dp_reg [DS+1];
    div_t              dp_next [DS+1];
    cau_pkg::result_t  out_reg, out_next;

    assign busy   = 1'b0;
    assign done   = vo_reg;
    assign result = out_reg;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vd_reg <= '0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vd_reg <= {vd_reg[DS-1:0], v3_reg};
            vo_reg <= vd_reg[DS];
        end
    end

    // products
    always_comb
    begin
        s2_next.func = s1_reg.func;
        s2_next.p_rr = PW'(s1_reg.a_re * s1_reg.b_re);
        s2_next.p_ii = PW'(s1_reg.a_im * s1_reg.b_im);
        s2_next.p_ri = PW'(s1_reg.a_re * s1_reg.b_im);
        s2_next.p_ir = PW'(s1_reg.a_im * s1_reg.b_re);
        s2_next.br2  = PW'(s1_reg.b_re * s1_reg.b_re);
        s2_next.bi2  = PW'(s1_reg.b_im * s1_reg.b_im);
        s2_next.a_re = s1_reg.a_re;
        s2_next.a_im = s1_reg.a_im;
        s2_next.b_re = s1_reg.b_re;
        s2_next.b_im = s1_reg.b_im;
    end

    // sums and denominator
    always_comb
    begin
        s3_next.func = s2_reg.func;
        s3_next.den  = s2_reg.br2 + s2_reg.bi2;
        unique case (s2_reg.func)
            cau_pkg::FUNC_ADD:
            begin
                s3_next.sum_re = SW'(s2_reg.a_re) + SW'(s2_reg.b_re);
                s3_next.sum_im = SW'(s2_reg.a_im) + SW'(s2_reg.b_im);
            end
            cau_pkg::FUNC_SUB:
            begin
                s3_next.sum_re = SW'(s2_reg.a_re) - SW'(s2_reg.b_re);
                s3_next.sum_im = SW'(s2_reg.a_im) - SW'(s2_reg.b_im);
            end
            cau_pkg::FUNC_MUL:
            begin
                s3_next.sum_re = SW'(s2_reg.p_rr) - SW'(s2_reg.p_ii);
                s3_next.sum_im = SW'(s2_reg.p_ri) + SW'(s2_reg.p_ir);
            end
            default:
            begin
                s3_next.sum_re = SW'(s2_reg.p_rr) + SW'(s2_reg.p_ii);
                s3_next.sum_im = SW'(s2_reg.p_ir) - SW'(s2_reg.p_ri);
            end
        endcase
    end

    // divide setup; non-divide results finish here and ride along
    always_comb
    begin
        logic [SW-1:0]        mag_re;
        logic [SW-1:0]        mag_im;
        logic signed [SW-1:0] val_re;
        logic signed [SW-1:0] val_im;
        cau_pkg::satv_t       sr;
        cau_pkg::satv_t       si;
        mag_re = s3_reg.sum_re[SW-1] ? SW'(-s3_reg.sum_re) : SW'(s3_reg.sum_re);
        mag_im = s3_reg.sum_im[SW-1] ? SW'(-s3_reg.sum_im) : SW'(s3_reg.sum_im);
        if (s3_reg.func == cau_pkg::FUNC_MUL)
        begin
            val_re = s3_reg.sum_re >>> FB;
            val_im = s3_reg.sum_im >>> FB;
        end
        else
        begin
            val_re = s3_reg.sum_re;
            val_im = s3_reg.sum_im;
        end
        sr = cau_pkg::sat_val(val_re);
        si = cau_pkg::sat_val(val_im);
        dp0_next.is_div = (s3_reg.func == cau_pkg::FUNC_DIV);
        dp0_next.divz   = (s3_reg.den == '0);
        dp0_next.re_neg = s3_reg.sum_re[SW-1];
        dp0_next.im_neg = s3_reg.sum_im[SW-1];
        dp0_next.re_ov  = (CW'(mag_re) << FB) >= (CW'(s3_reg.den) << DW);
        dp0_next.im_ov  = (CW'(mag_im) << FB) >= (CW'(s3_reg.den) << DW);
        dp0_next.rem_re = NW'(mag_re) << FB;
        dp0_next.rem_im = NW'(mag_im) << FB;
        dp0_next.q_re   = '0;
        dp0_next.q_im   = '0;
        dp0_next.den    = s3_reg.den;
        dp0_next.res.out_re = sr.v;
        dp0_next.res.out_im = si.v;
        dp0_next.res.status = (sr.sat || si.sat) ? cau_pkg::STAT_SAT : cau_pkg::STAT_OK;
    end

    // restoring divider, two quotient bits per stage
    always_comb
    begin
        int             bi;
        logic [CW-1:0]  trial;
        dp_next[0] = dp0_next;
        for (int s = 0; s < DS; s++)
        begin
            dp_next[s+1] = dp_reg[s];
            for (int k = 0; k < 2; k++)
            begin
                bi = DW - 1 - (2 * s + k);
                if (bi >= 0)
                begin
                    trial = CW'(dp_reg[s].den) << bi;
                    if (CW'(dp_next[s+1].rem_re) >= trial)
                    begin
                        dp_next[s+1].rem_re = NW'(CW'(dp_next[s+1].rem_re) - trial);
                        dp_next[s+1].q_re[bi] = 1'b1;
                    end
                    if (CW'(dp_next[s+1].rem_im) >= trial)
                    begin
                        dp_next[s+1].rem_im = NW'(CW'(dp_next[s+1].rem_im) - trial);
                        dp_next[s+1].q_im[bi] = 1'b1;
                    end
                end
            end
        end
    end

    // final sign and saturation of quotients
    always_comb
    begin
        logic sat_re;
        logic sat_im;
        div_t d;
        d = dp_reg[DS];
        sat_re = 1'b0;
        sat_im = 1'b0;
        out_next = d.res;
        if (d.is_div)
        begin
            if (d.divz)
            begin
                out_next.out_re = '0;
                out_next.out_im = '0;
                out_next.status = cau_pkg::STAT_DIVZ;
            end
            else
            begin
                if (!d.re_neg && (d.re_ov || d.q_re > Q_POS_MAX))
                begin
                    out_next.out_re = Q_POS_MAX;
                    sat_re = 1'b1;
                end
                else if (d.re_neg && (d.re_ov || d.q_re > Q_NEG_MAX))
                begin
                    out_next.out_re = Q_NEG_MAX;
                    sat_re = 1'b1;
                end
                else
                begin
                    out_next.out_re = d.re_neg ? -d.q_re : d.q_re;
                end
                if (!d.im_neg && (d.im_ov || d.q_im > Q_POS_MAX))
                begin
                    out_next.out_im = Q_POS_MAX;
                    sat_im = 1'b1;
                end
                else if (d.im_neg && (d.im_ov || d.q_im > Q_NEG_MAX))
                begin
                    out_next.out_im = Q_NEG_MAX;
                    sat_im = 1'b1;
                end
                else
                begin
                    out_next.out_im = d.im_neg ? -d.q_im : d.q_im;
                end
                out_next.status = (sat_re || sat_im) ? cau_pkg::STAT_SAT : cau_pkg::STAT_OK;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        s1_reg  <= req;
        s2_reg  <= s2_next;
        s3_reg  <= s3_next;
        for (int s = 0; s <= DS; s++)
        begin
            dp_reg[s] <= dp_next[s];
        end
        out_reg <= out_next;
    end

endmodule

/* rtl/cau_checker.sv */
// Port-level checker for complex_arithmetic_unit, bound into that module.
// Depends on cau_pkg.
module cau_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input cau_pkg::req_t    req,
    input logic             done,
    input cau_pkg::result_t result
);

    localparam logic signed [cau_pkg::DATA_WIDTH-1:0] MAXV =
        cau_pkg::DATA_WIDTH'((64'sd1 <<< (cau_pkg::DATA_WIDTH - 1)) - 1);
    localparam logic signed [cau_pkg::DATA_WIDTH-1:0] MINV = ~MAXV;

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_done_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, cau_pkg::LATENCY))
        else $error("result without a request");

    a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == cau_pkg::STAT_DIVZ) |->
        (result.out_re == '0 && result.out_im == '0))
        else $error("divide by zero with nonzero outputs");

    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == cau_pkg::STAT_SAT) |->
        (result.out_re == MAXV || result.out_re == MINV ||
         result.out_im == MAXV || result.out_im == MINV))
        else $error("saturation flagged without a limit value");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
);

/* dv/tb_top.sv */
// Testbench for complex_arithmetic_unit: directed and random complex add, subtract,
// multiply and divide requests, each checked against an in-bench arithmetic predictor.
// Depends on cau_pkg and the complex_arithmetic_unit RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = cau_pkg::DATA_WIDTH;
    localparam int FB = cau_pkg::FRAC_BITS;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    cau_pkg::req_t    req;
    logic             done;
    cau_pkg::result_t result;

    cau_pkg::result_t expected_q[$];
    int               mismatches = 0;

    complex_arithmetic_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // clamp one part into the output range, flag saturation
    function automatic logic signed [DW-1:0] clamp_part(input longint v,
                                                        inout logic sat);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (DW - 1)) - 1;
        lo = -(longint'(1) <<< (DW - 1));
        if (v > hi)
        begin
            sat = 1'b1;
            return DW'(hi);
        end
        if (v < lo)
        begin
            sat = 1'b1;
            return DW'(lo);
        end
        return DW'(v);
    endfunction

    // (n * 2^FRAC_BITS) / den, truncated toward zero
    function automatic longint scaled_quotient(input longint n, input longint den);
        longint mag;
        mag = ((n < 0 ? -n : n) <<< FB) / den;
        return (n < 0) ? -mag : mag;
    endfunction

    function automatic cau_pkg::result_t complex_result(input cau_pkg::req_t r);
        longint           ar;
        longint           ai;
        longint           br;
        longint           bi;
        longint           re;
        longint           im;
        longint           den;
        logic             sat;
        cau_pkg::result_t o;
        ar  = longint'(r.a_re);
        ai  = longint'(r.a_im);
        br  = longint'(r.b_re);
        bi  = longint'(r.b_im);
        sat = 1'b0;
        case (r.func)
            cau_pkg::FUNC_ADD:
            begin
                re = ar + br;
                im = ai + bi;
            end
            cau_pkg::FUNC_SUB:
            begin
                re = ar - br;
                im = ai - bi;
            end
            cau_pkg::FUNC_MUL:
            begin
                // arithmetic shift floors toward minus infinity
                re = (ar * br - ai * bi) >>> FB;
                im = (ar * bi + ai * br) >>> FB;
            end
            default:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                begin
                    o.out_re = '0;
                    o.out_im = '0;
                    o.status = cau_pkg::STAT_DIVZ;
                    return o;
                end
                re = scaled_quotient(ar * br + ai * bi, den);
                im = scaled_quotient(ai * br - ar * bi, den);
            end
        endcase
        o.out_re = clamp_part(re, sat);
        o.out_im = clamp_part(im, sat);
        o.status = sat ? cau_pkg::STAT_SAT : cau_pkg::STAT_OK;
        return o;
    endfunction

    // hold the request until accepted, then idle at random
    task automatic send_request(input cau_pkg::req_t r, input int idle_pct);
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        expected_q.push_back(complex_result(r));
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send_fields(input cau_pkg::func_t f, input int are, input int aim,
                               input int bre, input int bim);
        cau_pkg::req_t r;
        r.func = f;
        r.a_re = DW'(are);
        r.a_im = DW'(aim);
        r.b_re = DW'(bre);
        r.b_im = DW'(bim);
        send_request(r, 0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
                report_mismatch($sformatf("unexpected result %p", result));
            else
            begin
                cau_pkg::result_t e;
                e = expected_q.pop_front();
                if (result.out_re !== e.out_re)
                    report_mismatch($sformatf("out_re %0d, want %0d",
                                              result.out_re, e.out_re));
                if (result.out_im !== e.out_im)
                    report_mismatch($sformatf("out_im %0d, want %0d",
                                              result.out_im, e.out_im));
                if (result.status !== e.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              result.status, e.status));
            end
        end
    end

    task automatic test_directed();
        send_fields(cau_pkg::FUNC_ADD, 32767, -32768, 1, -1);
        send_fields(cau_pkg::FUNC_ADD, 100, -200, 300, 400);
        send_fields(cau_pkg::FUNC_ADD, -32768, 32767, -32768, 32767);
        send_fields(cau_pkg::FUNC_SUB, -32768, 32767, 1, -1);
        send_fields(cau_pkg::FUNC_SUB, 32767, -32768, 32767, -32768);
        send_fields(cau_pkg::FUNC_SUB, 0, 0, -32768, -32768);
        send_fields(cau_pkg::FUNC_MUL, 256, 0, 256, 0);
        send_fields(cau_pkg::FUNC_MUL, -1, 1, 1, 1);
        send_fields(cau_pkg::FUNC_MUL, 32767, 32767, 32767, -32768);
        send_fields(cau_pkg::FUNC_MUL, -32768, -32768, -32768, 32767);
        send_fields(cau_pkg::FUNC_MUL, 3, -5, -7, 11);
        send_fields(cau_pkg::FUNC_MUL, 0, 0, -32768, 32767);
        // zero divisor
        send_fields(cau_pkg::FUNC_DIV, 1234, -5678, 0, 0);
        send_fields(cau_pkg::FUNC_DIV, 0, 0, 0, 0);
        send_fields(cau_pkg::FUNC_DIV, 256, 256, 256, 0);
        send_fields(cau_pkg::FUNC_DIV, 32767, -32768, 1, 0);
        send_fields(cau_pkg::FUNC_DIV, -32768, -32768, 0, -1);
        send_fields(cau_pkg::FUNC_DIV, 1, 0, -32768, -32768);
        send_fields(cau_pkg::FUNC_DIV, -1, 1, 32767, 32767);
        send_fields(cau_pkg::FUNC_DIV, -300, 77, 3, -1);
        send_fields(cau_pkg::FUNC_DIV, 5, -3, -32768, 0);
        send_fields(cau_pkg::FUNC_DIV, 32767, 32767, -1, -1);
    endtask

    task automatic test_random(input int count, input int idle_pct);
        cau_pkg::req_t r;
        int            shape;
        for (int i = 0; i < count; i++)
        begin
            r      = cau_pkg::req_t'({$urandom, $urandom, $urandom});
            r.func = cau_pkg::func_t'($urandom_range(3));
            shape  = $urandom_range(9);
            // small operands keep most results off the rails
            if (shape < 4)
            begin
                r.a_re = DW'($urandom_range(0, 1023) - 512);
                r.a_im = DW'($urandom_range(0, 1023) - 512);
                r.b_re = DW'($urandom_range(0, 1023) - 512);
                r.b_im = DW'($urandom_range(0, 1023) - 512);
            end
            else if (shape == 4)
            begin
                r.b_re = '0;
                r.b_im = '0;
            end
            else if (shape == 5)
                r.b_im = DW'($urandom_range(0, 6) - 3);
            send_request(r, idle_pct);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(145, 10);
        test_random(145, 68);
        test_random(145, 0);
        start <= 1'b0;

        for (int w = 0; w < 1000 && expected_q.size() != 0; w++)
            @(posedge clk);
        repeat (cau_pkg::LATENCY + 5) @(posedge clk);

        if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
        if (mismatches == 0)
            $display("complex_arithmetic_unit verification clean");
        else
            $display("complex_arithmetic_unit verification failed");
        $finish;
    end

    initial
    begin
        #200000;
        $display("complex_arithmetic_unit verification failed");
        $finish;
    end

endmodule
